// ===== rtl/tbm_pkg.sv =====
// Shared types and constants of the temperature batch monitor.
// Used by the controller, the datapath, the top level and the checker.
package tbm_pkg;

  // Longest batch that the position counter has to cover.
  localparam int MAX_BATCH = 128;

  localparam int SAMPLE_W  = 16;
  localparam int T_W       = 15;
  localparam int CNT_W     = 8;
  localparam int SUM_W     = 22;
  localparam int POS_W     = 7;
  localparam int CFG_IDX_W = 2;

  // The position counter stops at the smaller of MAX_BATCH - 1 and the
  // largest value of the position field.
  localparam int POS_FIELD_MAX = (1 << POS_W) - 1;
  localparam int POS_CAP       = (MAX_BATCH - 1 < POS_FIELD_MAX) ?
                                 (MAX_BATCH - 1) : POS_FIELD_MAX;

  // The mean is found by a restoring divider, one quotient bit per cycle.
  localparam int DIV_STEPS = SUM_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [T_W-1:0] WARN_RESET     = T_W'(480);
  localparam logic [T_W-1:0] CRIT_RESET     = T_W'(720);
  localparam logic [T_W-1:0] SHUTDOWN_RESET = T_W'(800);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WARN     = 2'd0,
    CFG_CRIT     = 2'd1,
    CFG_SHUTDOWN = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    BIN_NORMAL   = 2'd0,
    BIN_WARNING  = 2'd1,
    BIN_CRITICAL = 2'd2,
    BIN_SHUTDOWN = 2'd3
  } bin_t;

  typedef enum logic [1:0] {
    ST_ACCUM,
    ST_DLOAD,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
  } in_item_t;

  typedef struct packed {
    logic [T_W-1:0]   min_temp;
    logic [T_W-1:0]   max_temp;
    logic [T_W-1:0]   mean_temp;
    logic [CNT_W-1:0] valid_total;
    logic [CNT_W-1:0] normal_count;
    logic [CNT_W-1:0] warning_count;
    logic [CNT_W-1:0] critical_count;
    logic [CNT_W-1:0] shutdown_count;
    logic [CNT_W-1:0] error_count;
    logic [POS_W-1:0] first_critical_pos;
    logic             critical_seen;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accum;     // fold the incoming sample into the batch state
    logic div_load;  // load the divider with the running sum
    logic div_step;  // produce one quotient bit
    logic load_out;  // capture the summary and clear the batch state
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_last;  // the current divider step is the final one
  } dp_status_t;

endpackage

// ===== rtl/tbm_ctrl.sv =====
// Controller of the temperature batch monitor: accept, divide and hand-off sequence.
// Depends on tbm_pkg for the state type and the command and status structs.
module tbm_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_last,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  tbm_pkg::dp_status_t status,
  output tbm_pkg::dp_cmd_t    cmd
);

  tbm_pkg::state_t state, state_next;
  logic            out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tbm_pkg::ST_ACCUM;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      tbm_pkg::ST_ACCUM: begin
        if (in_valid && in_last) begin
          state_next = tbm_pkg::ST_DLOAD;
        end
      end
      tbm_pkg::ST_DLOAD: state_next = tbm_pkg::ST_DIV;
      tbm_pkg::ST_DIV: begin
        if (status.div_last) begin
          state_next = tbm_pkg::ST_DONE;
        end
      end
      tbm_pkg::ST_DONE: begin
        if (!out_valid || out_ready) begin
          state_next = tbm_pkg::ST_ACCUM;
        end
      end
      default: state_next = tbm_pkg::ST_ACCUM;
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    cmd          = '0;
    case (state)
      tbm_pkg::ST_ACCUM: begin
        in_ready  = 1'b1;
        cmd.accum = in_valid;
      end
      tbm_pkg::ST_DLOAD: cmd.div_load = 1'b1;
      tbm_pkg::ST_DIV:   cmd.div_step = 1'b1;
      tbm_pkg::ST_DONE:  cmd.load_out = !out_valid || out_ready;
      default: begin
        in_ready = 1'b0;
        cmd      = '0;
      end
    endcase
  end

  // The output register is full from the summary load until its transfer.
  always_comb begin
    if (cmd.load_out) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

endmodule

// ===== rtl/tbm_dp.sv =====
// Datapath of the temperature batch monitor: thresholds, batch statistics,
// serial divider for the mean and the output register. Depends on tbm_pkg.
module tbm_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [tbm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tbm_pkg::T_W-1:0]             cfg_data,
  input  logic signed [tbm_pkg::SAMPLE_W-1:0] in_sample,
  input  tbm_pkg::dp_cmd_t                    cmd,
  output tbm_pkg::dp_status_t                 status,
  output tbm_pkg::out_item_t                  out_data
);

  localparam logic [tbm_pkg::POS_W-1:0] POS_CAP_V = tbm_pkg::POS_W'(tbm_pkg::POS_CAP);
  localparam logic [tbm_pkg::DIV_CNT_W-1:0] DIV_LAST =
    tbm_pkg::DIV_CNT_W'(tbm_pkg::DIV_STEPS - 1);

  function automatic logic [tbm_pkg::CNT_W-1:0] inc_sat(input logic [tbm_pkg::CNT_W-1:0] c);
    return (&c) ? c : c + tbm_pkg::CNT_W'(1);
  endfunction

  // Threshold registers.
  logic [tbm_pkg::T_W-1:0] warn_level, crit_level, shutdown_level;

  // Batch state.
  logic [tbm_pkg::SUM_W-1:0] running_sum;
  logic [tbm_pkg::CNT_W-1:0] valid_cnt;
  logic [tbm_pkg::T_W-1:0]   run_min, run_max;
  logic [tbm_pkg::CNT_W-1:0] bin_counts [4];
  logic [tbm_pkg::CNT_W-1:0] err_cnt;
  logic [tbm_pkg::POS_W-1:0] position;
  logic [tbm_pkg::POS_W-1:0] first_pos;
  logic                      seen_flag;

  // Divider state.
  logic [tbm_pkg::SUM_W-1:0]     quo;
  logic [tbm_pkg::CNT_W-1:0]     rem;
  logic [tbm_pkg::DIV_CNT_W-1:0] div_cnt;

  logic [tbm_pkg::T_W-1:0]   s;
  logic                      is_err;
  logic [tbm_pkg::SUM_W:0]   sum_ext;
  logic [tbm_pkg::SUM_W-1:0] sum_next;
  tbm_pkg::bin_t             bin;
  logic                      at_crit;
  logic [tbm_pkg::CNT_W:0]   trial;
  logic                      trial_ge;
  logic [tbm_pkg::T_W-1:0]   mean;

  assign s       = in_sample[tbm_pkg::T_W-1:0];
  assign is_err  = in_sample[tbm_pkg::SAMPLE_W-1];
  assign sum_ext = {1'b0, running_sum} + (tbm_pkg::SUM_W + 1)'(s);
  assign sum_next = sum_ext[tbm_pkg::SUM_W] ? '1 : sum_ext[tbm_pkg::SUM_W-1:0];
  assign at_crit = (s >= crit_level);

  // Bins are tried in order, so disordered thresholds still pick exactly one.
  always_comb begin
    if (s < warn_level) begin
      bin = tbm_pkg::BIN_NORMAL;
    end else if (s < crit_level) begin
      bin = tbm_pkg::BIN_WARNING;
    end else if (s <= shutdown_level) begin
      bin = tbm_pkg::BIN_CRITICAL;
    end else begin
      bin = tbm_pkg::BIN_SHUTDOWN;
    end
  end

  assign trial    = {rem, quo[tbm_pkg::SUM_W-1]};
  assign trial_ge = (trial >= {1'b0, valid_cnt});
  assign status.div_last = (div_cnt == DIV_LAST);

  always_comb begin
    if (valid_cnt == '0) begin
      mean = '0;
    end else if (|quo[tbm_pkg::SUM_W-1:tbm_pkg::T_W]) begin
      mean = '1;
    end else begin
      mean = quo[tbm_pkg::T_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      warn_level     <= tbm_pkg::WARN_RESET;
      crit_level     <= tbm_pkg::CRIT_RESET;
      shutdown_level <= tbm_pkg::SHUTDOWN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        tbm_pkg::CFG_WARN:     warn_level     <= cfg_data;
        tbm_pkg::CFG_CRIT:     crit_level     <= cfg_data;
        tbm_pkg::CFG_SHUTDOWN: shutdown_level <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.load_out) begin
      running_sum <= '0;
      valid_cnt   <= '0;
      run_min     <= '0;
      run_max     <= '0;
      for (int i = 0; i < 4; i++) begin
        bin_counts[i] <= '0;
      end
      err_cnt     <= '0;
      position    <= '0;
      first_pos   <= '0;
      seen_flag   <= 1'b0;
    end else if (cmd.accum) begin
      if (is_err) begin
        err_cnt <= inc_sat(err_cnt);
      end else begin
        if (at_crit && !seen_flag) begin
          seen_flag <= 1'b1;
          first_pos <= position;
        end
        if (valid_cnt == '0) begin
          run_min <= s;
          run_max <= s;
        end else begin
          if (s < run_min) run_min <= s;
          if (s > run_max) run_max <= s;
        end
        running_sum     <= sum_next;
        valid_cnt       <= inc_sat(valid_cnt);
        bin_counts[bin] <= inc_sat(bin_counts[bin]);
      end
      if (position < POS_CAP_V) begin
        position <= position + tbm_pkg::POS_W'(1);
      end
    end
  end

  // Restoring division of the running sum by the valid count.
  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      quo     <= running_sum;
      rem     <= '0;
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      if (trial_ge) begin
        rem <= tbm_pkg::CNT_W'(trial - {1'b0, valid_cnt});
      end else begin
        rem <= trial[tbm_pkg::CNT_W-1:0];
      end
      quo     <= {quo[tbm_pkg::SUM_W-2:0], trial_ge};
      div_cnt <= div_cnt + tbm_pkg::DIV_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data.min_temp           <= run_min;
      out_data.max_temp           <= run_max;
      out_data.mean_temp          <= mean;
      out_data.valid_total        <= valid_cnt;
      out_data.normal_count       <= bin_counts[tbm_pkg::BIN_NORMAL];
      out_data.warning_count      <= bin_counts[tbm_pkg::BIN_WARNING];
      out_data.critical_count     <= bin_counts[tbm_pkg::BIN_CRITICAL];
      out_data.shutdown_count     <= bin_counts[tbm_pkg::BIN_SHUTDOWN];
      out_data.error_count        <= err_cnt;
      out_data.first_critical_pos <= first_pos;
      out_data.critical_seen      <= seen_flag;
    end
  end

endmodule

// ===== rtl/temperature_batch_monitor_unit.sv =====
// Top level of the temperature batch monitor.
// Depends on tbm_pkg, tbm_ctrl and tbm_dp.
//
// Usage: samples arrive on the in channel (in_valid, in_ready, in_data), one
// signed 1/16 degree sample per transfer, with in_data.last marking the final
// sample of a batch. Negative samples count as sensor errors. One summary per
// batch leaves on the out channel (out_valid, out_ready, out_data).
// Thresholds are written through cfg_we, cfg_index and cfg_data while idle;
// index 0 is the warning level, 1 the critical level, 2 the shutdown level,
// and index 3 is ignored.
// Throughput: a batch streams at one sample per clock while in_ready is high. A
// sample with the last flag starts the mean calculation, a restoring divider
// that yields one quotient bit per cycle over the 22-bit running sum; in_ready
// stays low from that transfer through the divider load, the division and the
// summary load, and the summary then shows on out_valid.
// A waiting summary sits in the output register, so the next batch streams
// in even while the receiver stalls; only the next summary waits for the
// register to be emptied before the batch state is cleared.
// Reset loads the default thresholds (480, 720, 800) and clears the batch.
module temperature_batch_monitor_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [tbm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tbm_pkg::T_W-1:0]       cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  tbm_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output tbm_pkg::out_item_t            out_data
);

  tbm_pkg::dp_cmd_t    cmd;
  tbm_pkg::dp_status_t status;

  // The controller sequences the accept, divide and summary hand-off.
  tbm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_last   (in_data.last),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // The datapath holds thresholds, batch statistics, divider and result.
  tbm_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_sample (in_data.sample),
    .cmd       (cmd),
    .status    (status),
    .out_data  (out_data)
  );

endmodule

// ===== rtl/tbm_checker.sv =====
// Port-level checks of the temperature batch monitor, bound to the top level.
// Depends on tbm_pkg and temperature_batch_monitor_unit.
module tbm_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          out_valid,
  input logic                          out_ready,
  input tbm_pkg::out_item_t            out_data
);

  logic [tbm_pkg::CNT_W+1:0] bin_sum;

  assign bin_sum = (tbm_pkg::CNT_W + 2)'(out_data.normal_count) +
                   (tbm_pkg::CNT_W + 2)'(out_data.warning_count) +
                   (tbm_pkg::CNT_W + 2)'(out_data.critical_count) +
                   (tbm_pkg::CNT_W + 2)'(out_data.shutdown_count);

  // A stalled summary holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("summary changed while stalled");

  // Without saturation every valid sample lands in exactly one bin.
  a_bin_total: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.valid_total != '1) |->
      bin_sum == (tbm_pkg::CNT_W + 2)'(out_data.valid_total))
    else $error("bin counts do not add up to the valid total");

  // An empty batch reports zero temperatures.
  a_empty_batch: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.valid_total == '0) |->
      out_data.min_temp == '0 && out_data.max_temp == '0 && out_data.mean_temp == '0)
    else $error("empty batch reported temperatures");

  a_min_max: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.valid_total != '0) |-> out_data.min_temp <= out_data.max_temp)
    else $error("minimum above maximum");

  a_first_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.critical_seen |-> out_data.first_critical_pos == '0)
    else $error("critical position without a critical sample");

endmodule

bind temperature_batch_monitor_unit tbm_checker u_tbm_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ===== test/tb_top.sv =====
// Self-checking testbench for temperature_batch_monitor_unit.
// Needs only tbm_pkg and the RTL of the unit; it drives batches of samples,
// predicts each batch summary and checks the summaries the unit delivers.
module tb_top;
  import tbm_pkg::*;

  // Index 3 is outside the register map; a write to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam logic [SUM_W-1:0]     SUM_LIMIT = '1;
  localparam logic [T_W-1:0]       T_LIMIT   = '1;

  // Clock, reset and every input of the unit start at known values.
  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_WARN;
  logic [T_W-1:0]       cfg_data  = '0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  // When set, the sender and the receiver each draw a random wait per
  // transfer; when clear, that side runs back to back.
  bit send_idle = 1'b1;
  bit recv_idle = 1'b1;

  int fail_count = 0;

  // Summaries predicted for batches whose last sample has been transferred,
  // oldest first.
  out_item_t summary_q[$];

  // Shadow of the threshold registers and of the batch state of the unit.
  logic [T_W-1:0]   lvl_warn, lvl_crit, lvl_shut;
  logic [SUM_W-1:0] acc_sum;
  logic [CNT_W-1:0] n_valid, n_err;
  logic [CNT_W-1:0] bin_tally [4];
  logic [T_W-1:0]   t_min, t_max;
  logic [7:0]       pos_ctr;
  logic [POS_W-1:0] crit_pos;
  logic             crit_hit;

  temperature_batch_monitor_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  // A hung handshake ends the run here. The slowest legal run is well under
  // a tenth of this time.
  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // ------------------------------------------------------------------------
  // Prediction
  // ------------------------------------------------------------------------

  // Counters of the unit stop at their all-ones value.
  function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

  // The end of a batch clears everything except the thresholds.
  function automatic void clear_tallies();
    acc_sum  = '0;
    n_valid  = '0;
    n_err    = '0;
    t_min    = '0;
    t_max    = '0;
    pos_ctr  = '0;
    crit_pos = '0;
    crit_hit = 1'b0;
    foreach (bin_tally[k]) bin_tally[k] = '0;
  endfunction

  // Folds one transferred sample into the shadow state. On the last sample
  // of a batch the expected summary is queued and the state is cleared.
  function automatic void fold_sample(input in_item_t it);
    logic [T_W-1:0]   s;
    logic [SUM_W:0]   wide_sum;
    logic [SUM_W-1:0] quot;
    bin_t             b;
    out_item_t        sm;
    if (it.sample[SAMPLE_W-1]) begin
      // A negative sample is a sensor error: counted, otherwise skipped.
      n_err = bump(n_err);
    end else begin
      s = it.sample[T_W-1:0];
      if (s >= lvl_crit && !crit_hit) begin
        crit_hit = 1'b1;
        crit_pos = pos_ctr[POS_W-1:0];
      end
      if (n_valid == 0) begin
        t_min = s;
        t_max = s;
      end else begin
        if (s < t_min) t_min = s;
        if (s > t_max) t_max = s;
      end
      wide_sum = {1'b0, acc_sum} + (SUM_W + 1)'(s);
      acc_sum  = (wide_sum > SUM_LIMIT) ? SUM_LIMIT : wide_sum[SUM_W-1:0];
      n_valid  = bump(n_valid);
      // Bins are tried in a fixed order, so disordered thresholds still
      // place every sample in exactly one bin.
      if (s < lvl_warn) b = BIN_NORMAL;
      else if (s < lvl_crit) b = BIN_WARNING;
      else if (s <= lvl_shut) b = BIN_CRITICAL;
      else b = BIN_SHUTDOWN;
      bin_tally[b] = bump(bin_tally[b]);
    end
    // Error samples advance the position too; the counter stops at its cap.
    if (pos_ctr < POS_CAP) pos_ctr++;
    if (it.last) begin
      quot = (n_valid != 0) ? acc_sum / n_valid : '0;
      sm.min_temp           = t_min;
      sm.max_temp           = t_max;
      sm.mean_temp          = (quot > T_LIMIT) ? T_LIMIT : quot[T_W-1:0];
      sm.valid_total        = n_valid;
      sm.normal_count       = bin_tally[BIN_NORMAL];
      sm.warning_count      = bin_tally[BIN_WARNING];
      sm.critical_count     = bin_tally[BIN_CRITICAL];
      sm.shutdown_count     = bin_tally[BIN_SHUTDOWN];
      sm.error_count        = n_err;
      sm.first_critical_pos = crit_hit ? crit_pos : '0;
      sm.critical_seen      = crit_hit;
      summary_q.push_back(sm);
      clear_tallies();
    end
  endfunction

  // ------------------------------------------------------------------------
  // Checking
  // ------------------------------------------------------------------------

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  function automatic void compare_summary(input out_item_t got);
    out_item_t want;
    if (summary_q.size() == 0) begin
      $error("summary with no batch pending: %p", got);
      fail_count++;
      return;
    end
    want = summary_q.pop_front();
    check_field("min_temp", 32'(want.min_temp), 32'(got.min_temp));
    check_field("max_temp", 32'(want.max_temp), 32'(got.max_temp));
    check_field("mean_temp", 32'(want.mean_temp), 32'(got.mean_temp));
    check_field("valid_total", 32'(want.valid_total), 32'(got.valid_total));
    check_field("normal_count", 32'(want.normal_count), 32'(got.normal_count));
    check_field("warning_count", 32'(want.warning_count), 32'(got.warning_count));
    check_field("critical_count", 32'(want.critical_count), 32'(got.critical_count));
    check_field("shutdown_count", 32'(want.shutdown_count), 32'(got.shutdown_count));
    check_field("error_count", 32'(want.error_count), 32'(got.error_count));
    check_field("first_critical_pos", 32'(want.first_critical_pos),
                32'(got.first_critical_pos));
    check_field("critical_seen", 32'(want.critical_seen), 32'(got.critical_seen));
  endfunction

  // Summary receiver. With a stall drawn, ready stays low until a summary is
  // offered and then through the drawn stall, so the stall lands while the
  // summary waits in the output register and the next batch streams in.
  // Signals are sampled right after the rising edge, where they still hold
  // the values that decided the transfer at that edge.
  initial begin : result_sink
    int stall;
    @(negedge rst);
    forever begin
      stall = recv_idle ? $urandom_range(0, 17) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        do @(posedge clk); while (!out_valid);
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      compare_summary(out_data);
    end
  end

  // ------------------------------------------------------------------------
  // Stimulus
  // ------------------------------------------------------------------------

  // Sends one sample. Valid is only lowered when a gap is drawn, so back to
  // back transfers keep it high without a second assignment in one step.
  task automatic send_sample(input logic [SAMPLE_W-1:0] raw, input logic lst);
    int       gap;
    in_item_t it;
    gap       = send_idle ? $urandom_range(0, 17) : 0;
    it.sample = raw;
    it.last   = lst;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    fold_sample(it);
  endtask

  // The sender pauses until every predicted summary has been checked, then
  // lets the divider latency pass once more before anything else happens.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (summary_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  // Register writes are only made while the unit is idle.
  task automatic set_level(input logic [CFG_IDX_W-1:0] idx, input logic [T_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_WARN:     lvl_warn = val;
      CFG_CRIT:     lvl_crit = val;
      CFG_SHUTDOWN: lvl_shut = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_levels(input logic [T_W-1:0] w, input logic [T_W-1:0] c,
                            input logic [T_W-1:0] sd);
    drain_results();
    set_level(CFG_WARN, w);
    set_level(CFG_CRIT, c);
    set_level(CFG_SHUTDOWN, sd);
  endtask

  // Random sample: sensor errors, values right at the current thresholds,
  // the range ends, the region of the default thresholds and the full range.
  function automatic logic [SAMPLE_W-1:0] pick_sample();
    int roll;
    int lvl;
    roll = $urandom_range(0, 99);
    if (roll < 10) return {1'b1, 15'($urandom)};
    if (roll < 25) begin
      case ($urandom_range(0, 2))
        0:       lvl = int'(lvl_warn);
        1:       lvl = int'(lvl_crit);
        default: lvl = int'(lvl_shut);
      endcase
      lvl = lvl + int'($urandom_range(0, 4)) - 2;
      if (lvl < 0) lvl = 0;
      if (lvl > 32767) lvl = 32767;
      return 16'(lvl);
    end
    if (roll < 30) return roll[0] ? 16'h7FFF : 16'h0000;
    if (roll < 65) return 16'($urandom_range(0, 1023));
    return {1'b0, 15'($urandom)};
  endfunction

  task automatic send_batch(input int len);
    int i;
    for (i = 0; i < len; i++) send_sample(pick_sample(), i == len - 1);
  endtask

  // A batch of valid samples drawn evenly from lo to hi.
  task automatic send_span(input int len, input int lo, input int hi);
    int i;
    for (i = 0; i < len; i++) send_sample(16'($urandom_range(lo, hi)), i == len - 1);
  endtask

  // ------------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------------

  // Reset thresholds: every bin boundary from both sides, the range ends, a
  // zero sample, both extreme error codes, and one-sample batches that are
  // an error only, a zero only and full scale only.
  task automatic test_directed();
    send_sample(16'd100, 1'b0);
    send_sample(16'd0, 1'b0);
    send_sample(16'd479, 1'b0);
    send_sample(16'd480, 1'b0);
    send_sample(16'd719, 1'b0);
    send_sample(16'd720, 1'b0);
    send_sample(16'd800, 1'b0);
    send_sample(16'd801, 1'b0);
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'h8000, 1'b0);
    send_sample(16'd500, 1'b1);
    send_sample(16'hFFFB, 1'b1);
    send_sample(16'd0, 1'b1);
    send_sample(16'h7FFF, 1'b1);
  endtask

  // Threshold extremes, disordered thresholds and a write to the unused
  // index, each followed by a few short random batches.
  task automatic test_levels();
    int k;
    set_levels(15'd0, 15'd0, 15'd0);
    for (k = 0; k < 3; k++) send_batch($urandom_range(1, 8));
    set_levels(15'h7FFF, 15'h7FFF, 15'h7FFF);
    for (k = 0; k < 3; k++) send_batch($urandom_range(1, 8));
    set_levels(15'd900, 15'd300, 15'd100);
    for (k = 0; k < 3; k++) send_batch($urandom_range(1, 8));
    drain_results();
    set_level(CFG_SPARE, 15'($urandom));
    for (k = 0; k < 3; k++) send_batch($urandom_range(1, 8));
  endtask

  // Batches longer than the position cap. The first one saturates the valid
  // count, the sum and the normal bin, and has its first critical sample
  // past the cap; the second one saturates the error count.
  task automatic test_long_batches();
    int i;
    set_levels(15'h7FFF, 15'h7FFF, 15'h7FFF);
    for (i = 0; i < 260; i++)
      send_sample((i < 256) ? 16'($urandom_range(16384, 32766)) : 16'h7FFF, i == 259);
    set_levels(WARN_RESET, CRIT_RESET, SHUTDOWN_RESET);
    for (i = 0; i < 260; i++)
      send_sample((i < 259) ? {1'b1, 15'($urandom)} : 16'd1000, i == 259);
  endtask

  // Random batches in six phases, each under new thresholds: ordered ones
  // near the common range, or any three values. One phase runs the sender
  // without gaps and another the receiver without stalls.
  task automatic test_random();
    int total;
    int phase;
    int len;
    int lv[$];
    total = 0;
    for (phase = 0; phase < 6; phase++) begin
      lv.delete();
      if (phase % 2 == 0) begin
        repeat (3) lv.push_back($urandom_range(0, 2047));
        lv.sort();
      end else begin
        repeat (3) lv.push_back($urandom_range(0, 32767));
      end
      set_levels(15'(lv[0]), 15'(lv[1]), 15'(lv[2]));
      send_idle = (phase != 2);
      recv_idle = (phase != 3);
      while (total < (phase + 1) * 12) begin
        len = $urandom_range(1, 12);
        send_batch(len);
        total += len;
      end
    end
    send_idle = 1'b1;
    recv_idle = 1'b1;
  endtask

  // Reset, the tests in turn, then wait for the last summary and report.
  initial begin
    lvl_warn = WARN_RESET;
    lvl_crit = CRIT_RESET;
    lvl_shut = SHUTDOWN_RESET;
    clear_tallies();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_levels();
    test_long_batches();
    test_random();
    drain_results();
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== temperature_batch_monitor_unit.f =====
rtl/tbm_pkg.sv
rtl/tbm_ctrl.sv
rtl/tbm_dp.sv
rtl/temperature_batch_monitor_unit.sv
rtl/tbm_checker.sv
test/tb_top.sv
